// ----- rtl/core/ccpg_pkg.sv -----
// Shared types, constants and helpers of the crank and cam pattern generator.
// No dependencies; every other file of the block imports this package.
package ccpg_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int SLOT_W        = $clog2(TABLE_DEPTH);
    localparam int COUNT_W       = 11;
    localparam int MAX_CHANNELS  = 3;
    localparam int PIN_W         = 3;
    localparam int BYTE_W        = 8;
    localparam int RPM_W         = 16;
    localparam int PERIOD_W      = 23;
    localparam int TIME_W        = 32;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 3;

    // Divider widths: dividend 60e6 fits 26 bits, rpm * slots fits 27 bits
    localparam int DIV_W         = 26;
    localparam int PROD_W        = RPM_W + COUNT_W;
    localparam int STEP_W        = $clog2(DIV_W);

    localparam logic [DIV_W-1:0] US_PER_MINUTE = DIV_W'(60000000);
    localparam logic [RPM_W-1:0] MIN_RPM       = RPM_W'(10);

    localparam logic [RPM_W-1:0]   RPM_RESET   = RPM_W'(1000);
    localparam logic [COUNT_W-1:0] SLOTS_RESET = COUNT_W'(1);
    localparam logic [1:0]         CHAN_RESET  = 2'd1;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_START   = 3'd2,
        OP_STOP    = 3'd3,
        OP_RESTART = 3'd4
    } ccpg_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPM      = 3'd0,
        CFG_SLOTS    = 3'd1,
        CFG_INVERT   = 3'd2,
        CFG_REVERSE  = 3'd3,
        CFG_CHANNELS = 3'd4
    } ccpg_cfg_idx_t;

    typedef struct packed {
        logic [PIN_W-1:0]   invert_mask;
        logic               reverse;
        logic [PIN_W-1:0]   chan_mask;
        logic [COUNT_W-1:0] slots;
    } ccpg_cfg_t;

    typedef struct packed {
        ccpg_op_t          op;
        logic [SLOT_W-1:0] table_index;
        logic [BYTE_W-1:0] table_byte;
    } ccpg_item_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pins;
        logic              edge_fired;
        logic [SLOT_W-1:0] slot_index;
        logic              cycle_wrap;
        logic [TIME_W-1:0] cycle_duration;
        logic              running;
    } ccpg_result_t;

    // Clamp the slot count register to 1..TABLE_DEPTH
    function automatic logic [COUNT_W-1:0] eff_slots(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] r;
        begin
            r = n;
            if (n == '0) r = COUNT_W'(1);
            if (n > COUNT_W'(TABLE_DEPTH)) r = COUNT_W'(TABLE_DEPTH);
            return r;
        end
    endfunction

    // Output mask from the channel count, clamped to 1..MAX_CHANNELS
    function automatic logic [PIN_W-1:0] chan_mask(input logic [1:0] c);
        logic [PIN_W-1:0] m;
        begin
            case (c)
                2'd2:    m = PIN_W'(3);
                2'd3:    m = PIN_W'(7);
                default: m = PIN_W'(1);
            endcase
            return m;
        end
    endfunction

endpackage

// ----- rtl/core/crank_cam_pattern_generator.sv -----
// Crank and cam pattern generator: top level with handshake, settings and result word.
// Depends on ccpg_pkg, ccpg_period_div and ccpg_pattern_core.
//
// Each input word is one operation: a one-microsecond tick, a table write, start, stop
// or restart. While running, ticks are counted; when a slot period has passed, the
// table byte of the current slot, XOR invert_mask and masked to channel_count pins, is
// driven out and the slot steps forward or backward with wrap. A forward wrap records
// the microseconds since the previous one. Every accepted word returns exactly one
// result word. An item is first accepted, during which the pattern memory read of the
// current slot is registered, and then executed, which loads the result register. A
// waiting result does not block acceptance of the next word; execution waits only for
// the result register to free up. The slot period is 60000000 / (rpm * slots), at
// least 1, worked out by a one-bit-per-cycle restoring divider after reset and after
// every write of rpm or the slot count: s_ready stays low from the last such write
// until the divider has finished its pass, and a write during a pass restarts it.
// Write settings only while no word is in flight. The pattern table has no reset;
// play only slots that have been written.
module crank_cam_pattern_generator import ccpg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_op,
    input  logic [SLOT_W-1:0]     s_table_index,
    input  logic [BYTE_W-1:0]     s_table_byte,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIN_W-1:0]      m_pins,
    output logic                  m_edge_fired,
    output logic [SLOT_W-1:0]     m_slot_index,
    output logic                  m_cycle_wrap,
    output logic [TIME_W-1:0]     m_cycle_duration,
    output logic                  m_running,
    // settings write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t               state_reg, state_next;

    logic [RPM_W-1:0]     rpm_reg;
    logic [COUNT_W-1:0]   slots_raw_reg;
    logic [PIN_W-1:0]     invert_reg;
    logic                 reverse_reg;
    logic [1:0]           chan_reg;
    logic                 recalc_reg;

    ccpg_item_t           item_reg;
    ccpg_cfg_t            cfg;
    ccpg_result_t         res;
    ccpg_result_t         out_reg;
    logic                 out_valid_reg;

    logic                 div_busy;
    logic [PERIOD_W-1:0]  period;
    logic                 accept;
    logic                 out_free;
    logic                 exec;

    // Settings: hold the raw register values, recalc the period after rpm or slot writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpm_reg       <= RPM_RESET;
            slots_raw_reg <= SLOTS_RESET;
            invert_reg    <= '0;
            reverse_reg   <= 1'b0;
            chan_reg      <= CHAN_RESET;
            recalc_reg    <= 1'b1;
        end else begin
            recalc_reg <= 1'b0;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RPM: begin
                        rpm_reg    <= cfg_wr_data[RPM_W-1:0];
                        recalc_reg <= 1'b1;
                    end
                    CFG_SLOTS: begin
                        slots_raw_reg <= cfg_wr_data[COUNT_W-1:0];
                        recalc_reg    <= 1'b1;
                    end
                    CFG_INVERT:   invert_reg  <= cfg_wr_data[PIN_W-1:0];
                    CFG_REVERSE:  reverse_reg <= cfg_wr_data[0];
                    CFG_CHANNELS: chan_reg    <= cfg_wr_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg.invert_mask = invert_reg;
    assign cfg.reverse     = reverse_reg;
    assign cfg.chan_mask   = chan_mask(chan_reg);
    assign cfg.slots       = eff_slots(slots_raw_reg);

    ccpg_period_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (recalc_reg),
        .rpm     (rpm_reg),
        .slots   (cfg.slots),
        .busy    (div_busy),
        .period  (period)
    );

    // Input side: take a word only in idle and with a settled period
    assign s_ready  = (state_reg == ST_IDLE) && !div_busy && !recalc_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign exec     = (state_reg == ST_EXEC) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.op          <= ccpg_op_t'(s_op);
            item_reg.table_index <= s_table_index;
            item_reg.table_byte  <= s_table_byte;
        end
    end

    ccpg_pattern_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .period  (period),
        .trim    (recalc_reg),
        .exec    (exec),
        .item    (item_reg),
        .res     (res)
    );

    // Result register: load on execute, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pins           = out_reg.pins;
    assign m_edge_fired     = out_reg.edge_fired;
    assign m_slot_index     = out_reg.slot_index;
    assign m_cycle_wrap     = out_reg.cycle_wrap;
    assign m_cycle_duration = out_reg.cycle_duration;
    assign m_running        = out_reg.running;

endmodule

// ----- rtl/core/ccpg_period_div.sv -----
// Slot period unit: rpm * slots, then a bit-serial restoring division of 60e6.
// Depends on ccpg_pkg.
module ccpg_period_div import ccpg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [RPM_W-1:0]    rpm,
    input  logic [COUNT_W-1:0]  slots,
    output logic                busy,
    output logic [PERIOD_W-1:0] period
);

    typedef enum logic [2:0] {
        DV_IDLE  = 3'b001,
        DV_MUL   = 3'b010,
        DV_SHIFT = 3'b100
    } dv_state_t;

    dv_state_t            state_reg, state_next;
    logic [RPM_W-1:0]     rpm_op_reg;
    logic [COUNT_W-1:0]   slots_op_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0]    step_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [PROD_W:0]      shifted;
    logic [PROD_W+1:0]    trial;

    // One quotient bit per cycle
    always_comb begin
        shifted  = {rem_reg, dvd_reg[DIV_W-1]};
        trial    = {1'b0, shifted} - {2'b00, prod_reg};
        rem_next = trial[PROD_W+1] ? shifted[PROD_W-1:0] : trial[PROD_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ~trial[PROD_W+1]};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:  state_next = DV_IDLE;
            DV_MUL:   state_next = DV_SHIFT;
            DV_SHIFT: if (step_reg == '0) state_next = DV_IDLE;
            default:  state_next = DV_IDLE;
        endcase
        // a new request restarts the pass from whatever stage it has reached
        if (start) state_next = DV_MUL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rpm_op_reg   <= (rpm < MIN_RPM) ? MIN_RPM : rpm;
            slots_op_reg <= slots;
        end
        case (state_reg)
            DV_MUL: begin
                prod_reg <= PROD_W'(rpm_op_reg) * PROD_W'(slots_op_reg);
                rem_reg  <= '0;
                dvd_reg  <= US_PER_MINUTE;
                quo_reg  <= '0;
                step_reg <= STEP_W'(DIV_W - 1);
            end
            DV_SHIFT: begin
                rem_reg  <= rem_next;
                dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
                quo_reg  <= quo_next;
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    period_reg <= (quo_next == '0) ? PERIOD_W'(1) : quo_next[PERIOD_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign busy   = (state_reg != DV_IDLE);
    assign period = period_reg;

endmodule

// ----- rtl/core/ccpg_pattern_core.sv -----
// Pattern playback: table memory, slot pointer, period counter and cycle timing.
// Depends on ccpg_pkg.
module ccpg_pattern_core import ccpg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  ccpg_cfg_t           cfg,
    input  logic [PERIOD_W-1:0] period,
    input  logic                trim,
    input  logic                exec,
    input  ccpg_item_t          item,
    output ccpg_result_t        res
);

    logic [BYTE_W-1:0]   pattern_mem [TABLE_DEPTH];
    logic [BYTE_W-1:0]   rd_data_reg;

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [PERIOD_W-1:0] count_reg, count_next, count_inc;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next, elapsed_inc;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [PIN_W-1:0]    pins_reg, pins_next;
    logic                run_reg, run_next;
    logic                fired, wrapped;
    logic [COUNT_W-1:0]  slot_up;

    // Registered read of the slot being played
    always_ff @(posedge aclk) begin
        rd_data_reg <= pattern_mem[slot_reg];
        if (exec && item.op == OP_WRITE) begin
            pattern_mem[item.table_index] <= item.table_byte;
        end
    end

    always_comb begin
        slot_next    = slot_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        last_next    = last_reg;
        pins_next    = pins_reg;
        run_next     = run_reg;
        fired        = 1'b0;
        wrapped      = 1'b0;
        count_inc    = count_reg + PERIOD_W'(1);
        elapsed_inc  = elapsed_reg + TIME_W'(1);
        slot_up      = COUNT_W'(slot_reg) + COUNT_W'(1);
        case (item.op)
            OP_TICK: begin
                elapsed_next = elapsed_inc;
                if (run_reg) begin
                    count_next = count_inc;
                    if (count_inc >= period) begin
                        count_next = '0;
                        fired      = 1'b1;
                        pins_next  = (rd_data_reg[PIN_W-1:0] ^ cfg.invert_mask) & cfg.chan_mask;
                        if (cfg.reverse) begin
                            if (slot_reg == '0 || COUNT_W'(slot_reg) >= cfg.slots) begin
                                slot_next = SLOT_W'(cfg.slots - COUNT_W'(1));
                            end else begin
                                slot_next = slot_reg - SLOT_W'(1);
                            end
                        end else if (slot_up >= cfg.slots) begin
                            slot_next    = '0;
                            wrapped      = 1'b1;
                            last_next    = elapsed_inc;
                            elapsed_next = '0;
                        end else begin
                            slot_next = slot_up[SLOT_W-1:0];
                        end
                    end
                end
            end
            OP_START: begin
                if (!run_reg) begin
                    count_next = '0;
                    run_next   = 1'b1;
                end
            end
            OP_STOP: begin
                if (run_reg) begin
                    run_next  = 1'b0;
                    pins_next = '0;
                end
            end
            OP_RESTART: begin
                slot_next    = '0;
                count_next   = '0;
                elapsed_next = '0;
                last_next    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            count_reg   <= '0;
            elapsed_reg <= '0;
            last_reg    <= '0;
            pins_reg    <= '0;
            run_reg     <= 1'b0;
        end else if (exec) begin
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
            last_reg    <= last_next;
            pins_reg    <= pins_next;
            run_reg     <= run_next;
        end else if (trim && COUNT_W'(slot_reg) >= cfg.slots) begin
            // drop a pointer left beyond a shortened pattern
            slot_reg <= '0;
        end
    end

    assign res.pins           = pins_next;
    assign res.edge_fired     = fired;
    assign res.slot_index     = slot_next;
    assign res.cycle_wrap     = wrapped;
    assign res.cycle_duration = last_next;
    assign res.running        = run_next;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the crank and cam pattern generator: drives operation words,
// predicts each result word and compares it field by field. Depends on ccpg_pkg and the RTL.
module tb_top;
    import ccpg_pkg::*;

    // Configuration index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    // Operation codes outside the defined set; the block must answer them unchanged
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    // Slots loaded before the random phases; slot counts there stay within them
    localparam int PLAY_SLOTS = 128;

    typedef struct packed {
        logic [2:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] data;
    } pattern_word_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Every input starts at a known value before the first edge
    logic                  s_valid       = 1'b0;
    logic [2:0]            s_op          = '0;
    logic [SLOT_W-1:0]     s_table_index = '0;
    logic [BYTE_W-1:0]     s_table_byte  = '0;
    logic                  m_ready       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;

    logic                  s_ready;
    logic                  m_valid;
    logic [PIN_W-1:0]      m_pins;
    logic                  m_edge_fired;
    logic [SLOT_W-1:0]     m_slot_index;
    logic                  m_cycle_wrap;
    logic [TIME_W-1:0]     m_cycle_duration;
    logic                  m_running;

    crank_cam_pattern_generator u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_table_index    (s_table_index),
        .s_table_byte     (s_table_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pins           (m_pins),
        .m_edge_fired     (m_edge_fired),
        .m_slot_index     (m_slot_index),
        .m_cycle_wrap     (m_cycle_wrap),
        .m_cycle_duration (m_cycle_duration),
        .m_running        (m_running),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Pattern generator prediction: shadow settings and state
    // ------------------------------------------------------------------
    logic [RPM_W-1:0]    rpm_r;
    logic [COUNT_W-1:0]  slots_r;
    logic [PIN_W-1:0]    invert_r;
    logic                reverse_r;
    logic [1:0]          chan_r;

    logic [BYTE_W-1:0]   table_mem [TABLE_DEPTH];
    logic [SLOT_W-1:0]   slot_ptr;
    logic [PERIOD_W-1:0] ticks;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   now_us;
    logic [TIME_W-1:0]   rev_start_us;
    logic [TIME_W-1:0]   rev_length_us;
    logic [PIN_W-1:0]    pin_state;
    logic                gen_running;

    // Words waiting for the driver, and result words waiting for the block
    pattern_word_t pending_words [$];
    ccpg_result_t  pattern_results [$];
    pattern_word_t next_word;
    ccpg_result_t  want;

    int mismatches    = 0;
    int words_seen    = 0;
    int stall_left    = 0;
    int send_gap_pct  = 0;
    int take_gap_pct  = 0;

    // Clamp the slot count to 1..TABLE_DEPTH
    function automatic int unsigned slots_in_use(input logic [COUNT_W-1:0] n);
        int unsigned r;
        r = 32'(n);
        if (r == 0) r = 1;
        if (r > TABLE_DEPTH) r = TABLE_DEPTH;
        return r;
    endfunction

    // Pins actually driven for a given channel count, clamped to 1..MAX_CHANNELS
    function automatic logic [PIN_W-1:0] lane_mask(input logic [1:0] c);
        int unsigned k;
        k = 32'(c);
        if (k == 0) k = 1;
        if (k > MAX_CHANNELS) k = MAX_CHANNELS;
        return PIN_W'((1 << k) - 1);
    endfunction

    // Microseconds per slot: one minute over rpm * slots, never below one tick
    function automatic logic [PERIOD_W-1:0] period_for(input logic [RPM_W-1:0] r,
                                                        input logic [COUNT_W-1:0] n);
        longint unsigned speed;
        longint unsigned quot;
        speed = 64'(r);
        if (speed < 64'(MIN_RPM)) speed = 64'(MIN_RPM);
        quot = 64'(US_PER_MINUTE) / (speed * 64'(slots_in_use(n)));
        if (quot == 0) quot = 1;
        return PERIOD_W'(quot);
    endfunction

    function automatic void reset_pattern();
        rpm_r         = RPM_RESET;
        slots_r       = SLOTS_RESET;
        invert_r      = '0;
        reverse_r     = 1'b0;
        chan_r        = CHAN_RESET;
        slot_ptr      = '0;
        ticks         = '0;
        now_us        = '0;
        rev_start_us  = '0;
        rev_length_us = '0;
        pin_state     = '0;
        gen_running   = 1'b0;
        period        = period_for(rpm_r, slots_r);
    endfunction

    // Mirror one register write in the shadow settings
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_RPM: begin
                rpm_r  = val[RPM_W-1:0];
                period = period_for(rpm_r, slots_r);
            end
            CFG_SLOTS: begin
                slots_r = val[COUNT_W-1:0];
                period  = period_for(rpm_r, slots_r);
                // a pointer past the new end restarts from slot zero
                if (32'(slot_ptr) >= slots_in_use(slots_r)) slot_ptr = '0;
            end
            CFG_INVERT:   invert_r  = val[PIN_W-1:0];
            CFG_REVERSE:  reverse_r = val[0];
            CFG_CHANNELS: chan_r    = val[1:0];
            default: ;
        endcase
    endfunction

    // Run one operation word through the shadow state and return its result word
    function automatic ccpg_result_t advance_pattern(input logic [2:0] op,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic [BYTE_W-1:0] data);
        ccpg_result_t       res;
        int unsigned        n;
        int unsigned        p;
        logic [BYTE_W-1:0]  played;
        res = '0;
        case (op)
            OP_TICK: begin
                // time base runs whether or not the pattern is playing
                now_us = now_us + TIME_W'(1);
                if (gen_running) begin
                    ticks = ticks + PERIOD_W'(1);
                    if (ticks >= period) begin
                        n      = slots_in_use(slots_r);
                        p      = 32'(slot_ptr);
                        played = table_mem[p];
                        ticks  = '0;
                        res.edge_fired = 1'b1;
                        pin_state = (played[PIN_W-1:0] ^ invert_r) & lane_mask(chan_r);
                        if (reverse_r) begin
                            p = (p == 0 || p >= n) ? n - 1 : p - 1;
                        end else begin
                            p = p + 1;
                            if (p >= n) begin
                                p = 0;
                                res.cycle_wrap = 1'b1;
                                rev_length_us  = now_us - rev_start_us;
                                rev_start_us   = now_us;
                            end
                        end
                        slot_ptr = SLOT_W'(p);
                    end
                end
            end
            OP_WRITE: table_mem[slot] = data;
            OP_START: begin
                if (!gen_running) begin
                    ticks       = '0;
                    gen_running = 1'b1;
                end
            end
            OP_STOP: begin
                if (gen_running) begin
                    gen_running = 1'b0;
                    pin_state   = '0;
                end
            end
            OP_RESTART: begin
                slot_ptr      = '0;
                ticks         = '0;
                rev_start_us  = now_us;
                rev_length_us = '0;
            end
            default: ;
        endcase
        res.pins           = pin_state;
        res.slot_index     = slot_ptr;
        res.cycle_duration = rev_length_us;
        res.running        = gen_running;
        return res;
    endfunction

    // Count a field mismatch; show only the first few in full
    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: %s expected %0h, got %0h", words_seen, name, exp_v, got_v);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued words, hold each one until the block takes it
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // a word taken at this edge is predicted now, in acceptance order
            if (s_valid && s_ready)
                pattern_results.push_back(advance_pattern(s_op, s_table_index, s_table_byte));
            // the channel is free once the current word has gone (or none was offered)
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_word      = pending_words.pop_front();
                    s_valid       <= 1'b1;
                    s_op          <= next_word.op;
                    s_table_index <= next_word.slot;
                    s_table_byte  <= next_word.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take result words, compare with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                if (pattern_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: result with nothing outstanding, pins %0h slot %0d",
                                 words_seen, m_pins, m_slot_index);
                end else begin
                    want = pattern_results.pop_front();
                    check_field("pins",           32'(want.pins),       32'(m_pins));
                    check_field("edge_fired",     32'(want.edge_fired), 32'(m_edge_fired));
                    check_field("slot_index",     32'(want.slot_index), 32'(m_slot_index));
                    check_field("cycle_wrap",     32'(want.cycle_wrap), 32'(m_cycle_wrap));
                    check_field("cycle_duration", want.cycle_duration,  m_cycle_duration);
                    check_field("running",        32'(want.running),    32'(m_running));
                end
                // every thousand words, hold off long enough to back the block up
                if (words_seen % 1000 == 300) stall_left = 150;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= take_gap_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_word(input logic [2:0] op, input logic [SLOT_W-1:0] slot,
                                       input logic [BYTE_W-1:0] data);
        pattern_word_t w;
        w.op   = op;
        w.slot = slot;
        w.data = data;
        pending_words.push_back(w);
    endfunction

    // Tick with random filler in the unused fields
    function automatic void queue_tick();
        queue_word(OP_TICK, SLOT_W'($urandom_range(1023, 0)), BYTE_W'($urandom_range(255, 0)));
    endfunction

    // Mostly ticks of a running pattern, salted with every other operation
    function automatic void queue_random_word();
        int unsigned roll;
        logic [2:0]  op;
        roll = $urandom_range(99);
        if (roll < 72)      op = OP_TICK;
        else if (roll < 80) op = OP_WRITE;
        else if (roll < 88) op = OP_START;
        else if (roll < 92) op = OP_STOP;
        else if (roll < 96) op = OP_RESTART;
        else                op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        queue_word(op, SLOT_W'($urandom_range(1023, 0)), BYTE_W'($urandom_range(255, 0)));
    endfunction

    function automatic void set_idling(input int send_pct, input int take_pct);
        send_gap_pct = send_pct;
        take_gap_pct = take_pct;
    endfunction

    // Wait until no word is queued, offered or outstanding and the block takes input;
    // sample between edges so every process of the last edge has settled
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || pattern_results.size() != 0 || !s_ready)
            @(negedge aclk);
    endtask

    // One register write per edge; end_reg_writes drops the enable after a group
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        apply_reg(idx, val);
    endtask

    task automatic end_reg_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Pick new settings; bias towards short slot periods so edges keep coming
    task automatic pick_settings(input bit all_regs);
        logic [CFG_DATA_W-1:0] val;
        bit                    wrote;
        wrote = 1'b0;
        if (all_regs || $urandom_range(1)) begin
            case ($urandom_range(9))
                0:       val = 16'd0;
                1:       val = 16'd9;
                2:       val = 16'd10;
                3:       val = 16'($urandom_range(65535, 0));
                default: val = 16'($urandom_range(65535, 15000));
            endcase
            set_reg(CFG_RPM, val);
            wrote = 1'b1;
        end
        if (all_regs || $urandom_range(1)) begin
            case ($urandom_range(9))
                0:       val = 16'd0;
                1:       val = 16'd1;
                2:       val = 16'(PLAY_SLOTS);
                3:       val = 16'($urandom_range(PLAY_SLOTS, 0));
                default: val = 16'($urandom_range(PLAY_SLOTS, PLAY_SLOTS / 2));
            endcase
            set_reg(CFG_SLOTS, val);
            wrote = 1'b1;
        end
        if (all_regs || $urandom_range(1)) begin
            set_reg(CFG_INVERT, 16'($urandom_range(7, 0)));
            wrote = 1'b1;
        end
        if (all_regs || $urandom_range(1)) begin
            set_reg(CFG_REVERSE, 16'($urandom_range(1, 0)));
            wrote = 1'b1;
        end
        if (all_regs || $urandom_range(1)) begin
            set_reg(CFG_CHANNELS, 16'($urandom_range(3, 0)));
            wrote = 1'b1;
        end
        if (wrote) end_reg_writes();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int order [PLAY_SLOTS];
        int i;
        int j;
        int tmp;
        int burst;
        int random_count;
        bit first_phase;

        reset_pattern();
        set_idling(19, 48);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // let the period divider finish its pass after reset
        wait_idle();

        // Directed: fastest speed, slot count above the table (clamped), channel count
        // zero (one pin), a write to a register that does not exist
        set_reg(CFG_RPM, 16'hFFFF);
        set_reg(CFG_SLOTS, 16'd2047);
        set_reg(CFG_INVERT, 16'd5);
        set_reg(CFG_REVERSE, 16'd0);
        set_reg(CFG_CHANNELS, 16'd0);
        set_reg(CFG_SPARE, 16'hA5A5);
        end_reg_writes();
        queue_word(OP_WRITE, 10'd0, 8'hFF);
        queue_word(OP_WRITE, 10'd1, 8'h00);
        queue_word(OP_WRITE, 10'd2, 8'hA5);
        queue_word(OP_WRITE, 10'd1023, 8'h5A);
        queue_word(OP_TICK, 10'd0, 8'h00);       // idle tick: time moves, nothing plays
        queue_word(OP_STOP, 10'h3FF, 8'hFF);     // stop while stopped
        queue_word(OP_START, 10'd0, 8'h00);
        queue_word(OP_START, 10'd0, 8'h00);      // start while running
        queue_word(OP_TICK, 10'd0, 8'h00);       // play slot 0
        queue_word(OP_TICK, 10'd0, 8'h00);       // play slot 1
        queue_word(OP_SPARE_LO, 10'h2AA, 8'h55);
        queue_word(OP_SPARE_HI, 10'h155, 8'hAA);
        queue_word(OP_STOP, 10'd0, 8'h00);       // pins drop to zero
        queue_word(OP_START, 10'd0, 8'h00);
        queue_word(OP_RESTART, 10'd0, 8'h00);
        queue_word(OP_TICK, 10'd0, 8'h00);
        wait_idle();

        // Step backwards across slot zero to the top of the table, all three pins
        set_reg(CFG_REVERSE, 16'd1);
        set_reg(CFG_CHANNELS, 16'd3);
        set_reg(CFG_INVERT, 16'd2);
        end_reg_writes();
        queue_word(OP_TICK, 10'd0, 8'h00);
        queue_word(OP_TICK, 10'd0, 8'h00);
        queue_word(OP_TICK, 10'd0, 8'h00);
        queue_word(OP_RESTART, 10'd0, 8'h00);
        wait_idle();

        // Speed below the minimum while running: period becomes long, count keeps going
        set_reg(CFG_RPM, 16'd0);
        set_reg(CFG_CHANNELS, 16'd2);
        set_reg(CFG_REVERSE, 16'd0);
        end_reg_writes();
        repeat (3) queue_word(OP_TICK, 10'd0, 8'h00);
        wait_idle();

        // Shorten the period under a count already past it: the next tick must fire
        set_reg(CFG_RPM, 16'hFFFF);
        end_reg_writes();
        queue_word(OP_TICK, 10'd0, 8'h00);
        queue_word(OP_STOP, 10'd0, 8'h00);
        wait_idle();

        // Slot count zero pulls the pointer back to slot zero; speed just under the floor
        set_reg(CFG_SLOTS, 16'd0);
        set_reg(CFG_RPM, 16'd9);
        end_reg_writes();
        queue_word(OP_RESTART, 10'd0, 8'h00);
        wait_idle();

        // Load the low slots in shuffled order so every slot the random phases reach is safe
        for (i = 0; i < PLAY_SLOTS; i++) order[i] = i;
        for (i = PLAY_SLOTS - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < PLAY_SLOTS; i++)
            queue_word(OP_WRITE, SLOT_W'(order[i]), BYTE_W'($urandom_range(255, 0)));
        wait_idle();

        // Random phases: new settings, then a burst of mostly running ticks
        set_idling(48, 19);
        random_count = 0;
        first_phase  = 1'b1;
        while (random_count < 150) begin
            pick_settings(first_phase);
            first_phase = 1'b0;
            burst = $urandom_range(40, 10);
            repeat (burst) queue_random_word();
            random_count += burst;
            wait_idle();
        end

        // One whole revolution at top speed, no idling: a forward wrap and its duration,
        // measured from a restart
        set_idling(0, 0);
        set_reg(CFG_RPM, 16'hFFFF);
        set_reg(CFG_SLOTS, 16'd3);
        set_reg(CFG_REVERSE, 16'd0);
        set_reg(CFG_CHANNELS, 16'd3);
        set_reg(CFG_INVERT, 16'($urandom_range(7, 0)));
        end_reg_writes();
        queue_word(OP_RESTART, 10'd0, 8'h00);
        queue_word(OP_START, 10'd0, 8'h00);
        repeat (930) queue_tick();
        queue_word(OP_STOP, 10'd0, 8'h00);
        wait_idle();

        // Give any stray result word time to show up
        repeat (4) @(posedge aclk);
        if (pattern_results.size() != 0) begin
            mismatches += pattern_results.size();
            $display("%0d result words never arrived", pattern_results.size());
        end
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Drop out if the block hangs
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ccpg_pkg.sv
rtl/core/ccpg_period_div.sv
rtl/core/ccpg_pattern_core.sv
rtl/core/crank_cam_pattern_generator.sv
test/tb_top.sv
